/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed: label");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition: label");

`endif

/* design/hcrc_pkg.sv */
// ----------------------------------------------------------------------------
// hcrc_pkg
// Shared types and constants of the proxy reply status checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcrc_pkg;

  localparam int HeaderMax = 4096;
  localparam int CountW    = $clog2(HeaderMax + 1);
  localparam int LenW      = 13;
  localparam int CodeW     = 10;
  localparam int VerdictW  = 3;

  localparam logic [VerdictW-1:0] VerdictOk        = 3'd0;
  localparam logic [VerdictW-1:0] VerdictBadLine   = 3'd1;
  localparam logic [VerdictW-1:0] VerdictNoDigits  = 3'd2;
  localparam logic [VerdictW-1:0] VerdictAuth      = 3'd3;
  localparam logic [VerdictW-1:0] VerdictOther     = 3'd4;
  localparam logic [VerdictW-1:0] VerdictTruncated = 3'd5;

  localparam logic [CodeW-1:0] CodeOk   = 10'd200;
  localparam logic [CodeW-1:0] CodeAuth = 10'd407;
  localparam logic [CodeW-1:0] CodeSat  = 10'd999;

  localparam int PrefixLen  = 9;
  localparam int MinLineLen = 12;

  localparam logic [31:0] Terminator = 32'h0D0A0D0A;

  typedef struct packed {
    logic [VerdictW-1:0] verdict;
    logic [CodeW-1:0]    status_code;
    logic [LenW-1:0]     header_length;
  } result_t;

  // Expected byte of the status line prefix; alt selects the 1.1 variant.
  function automatic logic [7:0] prefix_char(input logic [3:0] idx, input logic alt);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "H";
      4'd1:    c = "T";
      4'd2:    c = "T";
      4'd3:    c = "P";
      4'd4:    c = "/";
      4'd5:    c = "1";
      4'd6:    c = ".";
      4'd7:    c = alt ? "1" : "0";
      4'd8:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/hcrc_parse.sv */
// ----------------------------------------------------------------------------
// hcrc_parse
// Per-byte header scan state and verdict logic, one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcrc_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data,
  output logic                   res_valid,
  output hcrc_pkg::result_t      res
);

  localparam logic [1:0] PhaseBefore = 2'd0;
  localparam logic [1:0] PhaseRun    = 2'd1;
  localparam logic [1:0] PhaseDone   = 2'd2;
  localparam logic [1:0] PhaseNone   = 2'd3;

  logic [hcrc_pkg::CountW-1:0] byte_count, byte_count_next;
  logic [23:0]                 recent_bytes, recent_bytes_next;
  logic [1:0]                  prefix_flags, prefix_flags_next;
  logic [1:0]                  digit_phase, digit_phase_next;
  logic [hcrc_pkg::CodeW-1:0]  code_accumulator, code_accumulator_next;

  logic                        is_digit;
  logic [3:0]                  digit;
  logic [13:0]                 acc_mul;
  logic                        ended;

  assign is_digit = (data >= "0") && (data <= "9");
  assign digit    = 4'(data - 8'h30);
  // acc * 10 + digit, at most 9999
  assign acc_mul  = {1'b0, code_accumulator, 3'b000} + {3'b000, code_accumulator, 1'b0}
                  + {10'd0, digit};

  always_comb begin
    prefix_flags_next     = prefix_flags;
    digit_phase_next      = digit_phase;
    code_accumulator_next = code_accumulator;

    if (byte_count < hcrc_pkg::CountW'(hcrc_pkg::PrefixLen)) begin
      if (data != hcrc_pkg::prefix_char(byte_count[3:0], 1'b0)) begin
        prefix_flags_next[0] = 1'b0;
      end
      if (data != hcrc_pkg::prefix_char(byte_count[3:0], 1'b1)) begin
        prefix_flags_next[1] = 1'b0;
      end
    end else if (byte_count == hcrc_pkg::CountW'(hcrc_pkg::PrefixLen)) begin
      if (is_digit) begin
        digit_phase_next      = PhaseRun;
        code_accumulator_next = {6'd0, digit};
      end else begin
        digit_phase_next = PhaseNone;
      end
    end else if (digit_phase == PhaseRun) begin
      if (is_digit) begin
        code_accumulator_next = (acc_mul > 14'd999) ? hcrc_pkg::CodeSat
                                                    : acc_mul[hcrc_pkg::CodeW-1:0];
      end else begin
        digit_phase_next = PhaseDone;
      end
    end

    byte_count_next   = byte_count + 1'b1;
    recent_bytes_next = {recent_bytes[15:0], data};
  end

  assign ended = (byte_count_next >= hcrc_pkg::CountW'(4))
              && ({recent_bytes, data} == hcrc_pkg::Terminator);

  always_comb begin
    res.status_code   = '0;
    res.header_length = byte_count_next[hcrc_pkg::LenW-1:0];
    res.verdict       = hcrc_pkg::VerdictTruncated;
    res_valid         = 1'b0;
    if (ended) begin
      res_valid = 1'b1;
      if (byte_count_next < hcrc_pkg::CountW'(hcrc_pkg::MinLineLen)
          || prefix_flags_next == 2'b00) begin
        res.verdict = hcrc_pkg::VerdictBadLine;
      end else if (digit_phase_next == PhaseNone || digit_phase_next == PhaseBefore) begin
        res.verdict = hcrc_pkg::VerdictNoDigits;
      end else begin
        res.status_code = code_accumulator_next;
        if (code_accumulator_next == hcrc_pkg::CodeOk) begin
          res.verdict = hcrc_pkg::VerdictOk;
        end else if (code_accumulator_next == hcrc_pkg::CodeAuth) begin
          res.verdict = hcrc_pkg::VerdictAuth;
        end else begin
          res.verdict = hcrc_pkg::VerdictOther;
        end
      end
    end else if (byte_count_next >= hcrc_pkg::CountW'(hcrc_pkg::HeaderMax)) begin
      res_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && res_valid)) begin
      byte_count       <= '0;
      recent_bytes     <= '0;
      prefix_flags     <= 2'b11;
      digit_phase      <= PhaseBefore;
      code_accumulator <= '0;
    end else if (step) begin
      byte_count       <= byte_count_next;
      recent_bytes     <= recent_bytes_next;
      prefix_flags     <= prefix_flags_next;
      digit_phase      <= digit_phase_next;
      code_accumulator <= code_accumulator_next;
    end
  end

endmodule

`default_nettype wire

/* design/hcrc_out_buf.sv */
// ----------------------------------------------------------------------------
// hcrc_out_buf
// Two-entry result buffer between the scan stage and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcrc_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire hcrc_pkg::result_t push_data,
  output logic                   has_room,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output hcrc_pkg::result_t      pop_data
);

  hcrc_pkg::result_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       pop;

  assign has_room  = (fill != 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* design/http_connect_reply_checker_unit.sv */
// ----------------------------------------------------------------------------
// http_connect_reply_checker_unit
// Status line checker for HTTP proxy replies, one header byte per transfer.
// ----------------------------------------------------------------------------
// Feed the reply header one byte per transfer on the byte channel. The block
// takes one byte every clock cycle as long as the result side keeps up; the
// rate is set by the scan stage, whose state update for one byte finishes
// before the next byte reaches it. A byte is scanned from the input register,
// and the verdict for the byte that ends the header (CR LF CR LF) or reaches
// the length limit is registered into the result buffer, from which it is
// offered on the result channel. Bytes that do not end a header
// give no result. A two-entry buffer holds verdicts while the result side
// stalls; the byte channel stalls only when both entries are full. After
// each verdict the scan state starts over for the next reply. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module http_connect_reply_checker_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte channel
  input  wire logic                           byte_valid,
  output logic                                byte_ready,
  input  wire logic [7:0]                     response_byte,
  // result channel
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic [hcrc_pkg::VerdictW-1:0]       verdict,
  output logic [hcrc_pkg::CodeW-1:0]          status_code,
  output logic [hcrc_pkg::LenW-1:0]           header_length
);

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;

  logic              advance;
  logic              buf_room;
  logic              scan_res_valid;
  hcrc_pkg::result_t scan_res;
  hcrc_pkg::result_t out_res;

  // the scanned byte moves on only if a verdict it may produce has a slot
  assign advance    = in_q_valid && buf_room;
  assign byte_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (byte_ready) begin
      in_q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      in_q_byte <= response_byte;
    end
  end

  hcrc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data      (in_q_byte),
    .res_valid (scan_res_valid),
    .res       (scan_res)
  );

  hcrc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && scan_res_valid),
    .push_data (scan_res),
    .has_room  (buf_room),
    .pop_valid (result_valid),
    .pop_ready (result_ready),
    .pop_data  (out_res)
  );

  assign verdict       = out_res.verdict;
  assign status_code   = out_res.status_code;
  assign header_length = out_res.header_length;

endmodule

`default_nettype wire

/* design/hcrc_checker.sv */
// ----------------------------------------------------------------------------
// hcrc_checker
// Port-level checks on the reply checker, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hcrc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic [hcrc_pkg::VerdictW-1:0]  verdict,
  input wire logic [hcrc_pkg::CodeW-1:0]     status_code,
  input wire logic [hcrc_pkg::LenW-1:0]      header_length
);

  logic absent_code;
  logic ok_out;
  logic auth_out;
  assign absent_code = (verdict == hcrc_pkg::VerdictBadLine)
                    || (verdict == hcrc_pkg::VerdictNoDigits)
                    || (verdict == hcrc_pkg::VerdictTruncated);
  assign ok_out   = result_valid && (verdict == hcrc_pkg::VerdictOk);
  assign auth_out = result_valid && (verdict == hcrc_pkg::VerdictAuth);

  // stalled verdict stays offered
  `ASSERT_CLK(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid)
  // ok and auth verdicts carry their own codes
  `ASSERT_CLK(a_ok_code, clk, rst, ok_out |-> status_code == hcrc_pkg::CodeOk)
  `ASSERT_CLK(a_auth_code, clk, rst, auth_out |-> status_code == hcrc_pkg::CodeAuth)
  // verdicts without a parsed code report zero
  `ASSERT_NEVER(a_absent_code, clk, rst, result_valid && absent_code && status_code != '0)
  // a header needs at least four bytes to end, HeaderMax bytes to be cut off
  `ASSERT_NEVER(a_len_zero, clk, rst, result_valid && header_length == '0)

endmodule

bind http_connect_reply_checker_unit hcrc_checker u_hcrc_checker (.*);

`default_nettype wire
